>>> design/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Widths and types shared by the oriented box overlap pipeline.
// ----------------------------------------------------------------------------
package obb_pkg;

   // Width of every coordinate and edge component, signed two's complement.
   localparam int COORD_BITS = 16;

   // The center difference needs one more bit than a coordinate.
   localparam int DIFF_BITS  = COORD_BITS + 1;

   // Edge by edge product, and the dot product of an edge pair.
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int DOT_BITS   = PROD_BITS + 1;

   // Edge by center difference product, and its dot product.
   localparam int CPROD_BITS = COORD_BITS + DIFF_BITS;
   localparam int CDOT_BITS  = CPROD_BITS + 1;

   // Magnitudes keep the full signed width so the most negative value fits.
   localparam int MAG_BITS   = DOT_BITS;
   localparam int CMAG_BITS  = CDOT_BITS;

   // Sum of the NUM_EDGES edge magnitudes, and the doubled center magnitude.
   localparam int SUM_BITS   = MAG_BITS + 2;
   localparam int CEN2_BITS  = CMAG_BITS + 1;

   // Common width for the final comparison.
   localparam int CMP_BITS   = (SUM_BITS > CEN2_BITS) ? SUM_BITS : CEN2_BITS;

   localparam int NUM_EDGES  = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [DOT_BITS-1:0]   dot_type;
   typedef logic signed [CPROD_BITS-1:0] cprod_type;
   typedef logic signed [CDOT_BITS-1:0]  cdot_type;
   typedef logic [MAG_BITS-1:0]          mag_type;
   typedef logic [CMAG_BITS-1:0]         cmag_type;
   typedef logic [SUM_BITS-1:0]          sum_type;
   typedef logic [CEN2_BITS-1:0]         cen2_type;
   typedef logic [CMP_BITS-1:0]          cmp_type;

endpackage

>>> design/oriented_box_overlap_2d_top.sv
// ----------------------------------------------------------------------------
// oriented_box_overlap_2d_top
// Separating axis overlap test for two 2D oriented boxes, fully pipelined.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy is always low,
// so one box pair can enter each clock. The answer appears on rsp_overlap,
// marked by rsp_valid for exactly one cycle, in request order. The receiver
// cannot stall the result, and none is needed: five register stages (center
// difference, multipliers, dot product and magnitude, sums, compare) each
// hold one request and always advance.
// rsp_overlap is high when none of the NUM_EDGES edge axes separates the boxes;
// touching boxes count as overlapping.
// ----------------------------------------------------------------------------
module oriented_box_overlap_2d_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_left_u_x,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_left_u_y,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_left_v_x,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_left_v_y,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_left_center_x,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_left_center_y,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_right_u_x,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_right_u_y,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_right_v_x,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_right_v_y,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_right_center_x,
   input  logic signed [obb_pkg::COORD_BITS-1:0]  req_right_center_y,
   output logic                                   rsp_valid,
   output logic                                   rsp_overlap
);

   localparam int NE = obb_pkg::NUM_EDGES;

   // Stage 1: edges and center difference.
   obb_pkg::coord_type edge_in [NE][2];
   obb_pkg::coord_type edge_ff [NE][2];
   obb_pkg::diff_type  diff_in [2];
   obb_pkg::diff_type  diff_ff [2];
   logic               v1_ff;

   // Stage 2: products.
   obb_pkg::prod_type  prod_in  [NE][NE][2];
   obb_pkg::prod_type  prod_ff  [NE][NE][2];
   obb_pkg::cprod_type cprod_in [NE][2];
   obb_pkg::cprod_type cprod_ff [NE][2];
   logic               v2_ff;

   // Stage 3: dot product magnitudes.
   obb_pkg::dot_type   dot_in  [NE][NE];
   obb_pkg::mag_type   mag_in  [NE][NE];
   obb_pkg::mag_type   mag_ff  [NE][NE];
   obb_pkg::cdot_type  cdot_in [NE];
   obb_pkg::cmag_type  cmag_in [NE];
   obb_pkg::cmag_type  cmag_ff [NE];
   logic               v3_ff;

   // Stage 4: per axis projected extent and doubled center distance.
   obb_pkg::sum_type   sum_in  [NE];
   obb_pkg::sum_type   sum_ff  [NE];
   obb_pkg::cen2_type  cen2_in [NE];
   obb_pkg::cen2_type  cen2_ff [NE];
   logic               v4_ff;

   // Stage 5: result.
   logic [NE-1:0]      sep_in;
   logic               rsp_overlap_in;
   logic               rsp_overlap_ff;
   logic               rsp_valid_ff;

   assign busy = 1'b0;

   always_comb begin
      edge_in[0][0] = req_left_u_x;
      edge_in[0][1] = req_left_u_y;
      edge_in[1][0] = req_left_v_x;
      edge_in[1][1] = req_left_v_y;
      edge_in[2][0] = req_right_u_x;
      edge_in[2][1] = req_right_u_y;
      edge_in[3][0] = req_right_v_x;
      edge_in[3][1] = req_right_v_y;
      diff_in[0] = obb_pkg::DIFF_BITS'(req_right_center_x)
                 - obb_pkg::DIFF_BITS'(req_left_center_x);
      diff_in[1] = obb_pkg::DIFF_BITS'(req_right_center_y)
                 - obb_pkg::DIFF_BITS'(req_left_center_y);
   end

   always_comb begin
      for (int i = 0; i < NE; i++) begin
         for (int j = 0; j < NE; j++) begin
            for (int k = 0; k < 2; k++) begin
               prod_in[i][j][k] = obb_pkg::PROD_BITS'(edge_ff[i][k])
                                * obb_pkg::PROD_BITS'(edge_ff[j][k]);
            end
         end
         for (int k = 0; k < 2; k++) begin
            cprod_in[i][k] = obb_pkg::CPROD_BITS'(edge_ff[i][k])
                           * obb_pkg::CPROD_BITS'(diff_ff[k]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NE; i++) begin
         for (int j = 0; j < NE; j++) begin
            dot_in[i][j] = obb_pkg::DOT_BITS'(prod_ff[i][j][0])
                         + obb_pkg::DOT_BITS'(prod_ff[i][j][1]);
            mag_in[i][j] = dot_in[i][j][obb_pkg::DOT_BITS-1]
                         ? obb_pkg::mag_type'(-dot_in[i][j])
                         : obb_pkg::mag_type'(dot_in[i][j]);
         end
         cdot_in[i] = obb_pkg::CDOT_BITS'(cprod_ff[i][0])
                    + obb_pkg::CDOT_BITS'(cprod_ff[i][1]);
         cmag_in[i] = cdot_in[i][obb_pkg::CDOT_BITS-1]
                    ? obb_pkg::cmag_type'(-cdot_in[i])
                    : obb_pkg::cmag_type'(cdot_in[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NE; i++) begin
         sum_in[i] = obb_pkg::SUM_BITS'(mag_ff[i][0]) + obb_pkg::SUM_BITS'(mag_ff[i][1])
                   + obb_pkg::SUM_BITS'(mag_ff[i][2]) + obb_pkg::SUM_BITS'(mag_ff[i][3]);
         cen2_in[i] = {cmag_ff[i], 1'b0};
      end
   end

   // An axis separates when the projected extent falls strictly short of
   // twice the projected center distance.
   always_comb begin
      for (int i = 0; i < NE; i++) begin
         sep_in[i] = obb_pkg::CMP_BITS'(sum_ff[i]) < obb_pkg::CMP_BITS'(cen2_ff[i]);
      end
      rsp_overlap_in = ~(|sep_in);
   end

   always_ff @(posedge clock) begin
      edge_ff        <= edge_in;
      diff_ff        <= diff_in;
      prod_ff        <= prod_in;
      cprod_ff       <= cprod_in;
      mag_ff         <= mag_in;
      cmag_ff        <= cmag_in;
      sum_ff         <= sum_in;
      cen2_ff        <= cen2_in;
      rsp_overlap_ff <= rsp_overlap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= start;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

endmodule

>>> bench/obb_overlap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obb_overlap_checker
// Watches the request and result ports of the oriented box overlap block. For
// every request taken it works out the separating axis answer with exact
// 64-bit arithmetic and queues it. Each result is then compared in order
// against the oldest queued answer.
// ----------------------------------------------------------------------------
module obb_overlap_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  obb_pkg::coord_type req_left_u_x,
   input  obb_pkg::coord_type req_left_u_y,
   input  obb_pkg::coord_type req_left_v_x,
   input  obb_pkg::coord_type req_left_v_y,
   input  obb_pkg::coord_type req_left_center_x,
   input  obb_pkg::coord_type req_left_center_y,
   input  obb_pkg::coord_type req_right_u_x,
   input  obb_pkg::coord_type req_right_u_y,
   input  obb_pkg::coord_type req_right_v_x,
   input  obb_pkg::coord_type req_right_v_y,
   input  obb_pkg::coord_type req_right_center_x,
   input  obb_pkg::coord_type req_right_center_y,
   input  logic               rsp_valid,
   input  logic               rsp_overlap,
   output int                 mismatch_count,
   output int                 pending_count
);

   logic expected_overlap_q[$];

   // Separating axis test on the NUM_EDGES edge axes. Every term fits easily in
   // 64 bits: dot products stay below 2^34 even with the widest center gap.
   function automatic logic boxes_overlap(
      input obb_pkg::coord_type lux, input obb_pkg::coord_type luy,
      input obb_pkg::coord_type lvx, input obb_pkg::coord_type lvy,
      input obb_pkg::coord_type lcx, input obb_pkg::coord_type lcy,
      input obb_pkg::coord_type rux, input obb_pkg::coord_type ruy,
      input obb_pkg::coord_type rvx, input obb_pkg::coord_type rvy,
      input obb_pkg::coord_type rcx, input obb_pkg::coord_type rcy);
      longint ex[obb_pkg::NUM_EDGES];
      longint ey[obb_pkg::NUM_EDGES];
      longint dx, dy, proj, edge_sum, center_span;
      logic   hit;
      ex[0] = longint'(lux);  ey[0] = longint'(luy);
      ex[1] = longint'(lvx);  ey[1] = longint'(lvy);
      ex[2] = longint'(rux);  ey[2] = longint'(ruy);
      ex[3] = longint'(rvx);  ey[3] = longint'(rvy);
      dx  = longint'(rcx) - longint'(lcx);
      dy  = longint'(rcy) - longint'(lcy);
      hit = 1'b1;
      for (int a = 0; a < obb_pkg::NUM_EDGES; a++) begin
         edge_sum = 0;
         for (int e = 0; e < obb_pkg::NUM_EDGES; e++) begin
            proj = ex[a] * ex[e] + ey[a] * ey[e];
            edge_sum += (proj < 0) ? -proj : proj;
         end
         proj = ex[a] * dx + ey[a] * dy;
         center_span = 2 * ((proj < 0) ? -proj : proj);
         // Touching boxes leave both sides equal and still count as overlap.
         if (edge_sum < center_span) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin : watch_channels
      logic expected;
      if (reset) begin
         expected_overlap_q.delete();
         mismatch_count <= 0;
         pending_count  <= 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_overlap_q.size() == 0) begin
               $error("overlap result %0b arrived with no request outstanding", rsp_overlap);
               mismatch_count <= mismatch_count + 1;
            end else begin
               expected = expected_overlap_q.pop_front();
               if (rsp_overlap !== expected) begin
                  $error("overlap: expected %0b, actual %0b", expected, rsp_overlap);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            expected_overlap_q.push_back(boxes_overlap(
               req_left_u_x, req_left_u_y, req_left_v_x, req_left_v_y,
               req_left_center_x, req_left_center_y,
               req_right_u_x, req_right_u_y, req_right_v_x, req_right_v_y,
               req_right_center_x, req_right_center_y));
         end
         pending_count <= expected_overlap_q.size();
      end
   end

endmodule

>>> bench/tb_oriented_box_overlap_2d_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_oriented_box_overlap_2d_top
// Drives box pairs into the overlap block: a directed set of extremes,
// touching, degenerate and rotated boxes, then random pairs that are mostly
// near each other so that both answers are common. Gaps between requests are
// random, with bursts of back to back requests and a full drain halfway. Checking
// is done by obb_overlap_checker.
// ----------------------------------------------------------------------------
module tb_oriented_box_overlap_2d_top;

   localparam int RANDOM_REQUESTS = 1385;
   localparam int STALL_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 8;

   typedef struct {
      obb_pkg::coord_type lux, luy, lvx, lvy, lcx, lcy;
      obb_pkg::coord_type rux, ruy, rvx, rvy, rcx, rcy;
   } box_pair_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   obb_pkg::coord_type req_left_u_x       = '0;
   obb_pkg::coord_type req_left_u_y       = '0;
   obb_pkg::coord_type req_left_v_x       = '0;
   obb_pkg::coord_type req_left_v_y       = '0;
   obb_pkg::coord_type req_left_center_x  = '0;
   obb_pkg::coord_type req_left_center_y  = '0;
   obb_pkg::coord_type req_right_u_x      = '0;
   obb_pkg::coord_type req_right_u_y      = '0;
   obb_pkg::coord_type req_right_v_x      = '0;
   obb_pkg::coord_type req_right_v_y      = '0;
   obb_pkg::coord_type req_right_center_x = '0;
   obb_pkg::coord_type req_right_center_y = '0;
   logic               rsp_valid;
   logic               rsp_overlap;
   int                 mismatch_count;
   int                 pending_count;
   int                 idle_cycles = 0;

   oriented_box_overlap_2d_top dut (.*);

   obb_overlap_checker checker_inst (.*);

   always #5 clock = ~clock;

   // Ends the run if neither a request nor a result moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic box_pair_type make_pair(
      input int lux, input int luy, input int lvx, input int lvy,
      input int lcx, input int lcy, input int rux, input int ruy,
      input int rvx, input int rvy, input int rcx, input int rcy);
      box_pair_type p;
      p.lux = obb_pkg::coord_type'(lux);  p.luy = obb_pkg::coord_type'(luy);
      p.lvx = obb_pkg::coord_type'(lvx);  p.lvy = obb_pkg::coord_type'(lvy);
      p.lcx = obb_pkg::coord_type'(lcx);  p.lcy = obb_pkg::coord_type'(lcy);
      p.rux = obb_pkg::coord_type'(rux);  p.ruy = obb_pkg::coord_type'(ruy);
      p.rvx = obb_pkg::coord_type'(rvx);  p.rvy = obb_pkg::coord_type'(rvy);
      p.rcx = obb_pkg::coord_type'(rcx);  p.rcy = obb_pkg::coord_type'(rcy);
      return p;
   endfunction

   function automatic int near_value(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic obb_pkg::coord_type near_coord(input int span);
      return obb_pkg::coord_type'(near_value(span));
   endfunction

   function automatic obb_pkg::coord_type clip(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return obb_pkg::coord_type'(v);
   endfunction

   function automatic obb_pkg::coord_type corner_value();
      case ($urandom_range(0, 5))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return obb_pkg::coord_type'($urandom());
      endcase
   endfunction

   function automatic box_pair_type random_pair();
      box_pair_type p;
      int           kind, span, w, h;
      kind = $urandom_range(0, 9);
      if (kind <= 1) begin
         p = make_pair($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom());
      end else if (kind == 2) begin
         p.lux = corner_value();  p.luy = corner_value();
         p.lvx = corner_value();  p.lvy = corner_value();
         p.lcx = corner_value();  p.lcy = corner_value();
         p.rux = corner_value();  p.ruy = corner_value();
         p.rvx = corner_value();  p.rvy = corner_value();
         p.rcx = corner_value();  p.rcy = corner_value();
      end else if (kind == 9) begin
         // Equal axis-aligned boxes whose faces meet exactly along x or y.
         w = $urandom_range(1, 4000);
         h = $urandom_range(1, 4000);
         p = make_pair(w, 0, 0, h, near_value(8000), near_value(8000),
                       w, 0, 0, h, 0, 0);
         if ($urandom_range(0, 1)) begin
            p.rcx = obb_pkg::coord_type'(int'(p.lcx) + ($urandom_range(0, 1) ? w : -w));
            p.rcy = obb_pkg::coord_type'(int'(p.lcy) + near_value(h + 1));
         end else begin
            p.rcx = obb_pkg::coord_type'(int'(p.lcx) + near_value(w + 1));
            p.rcy = obb_pkg::coord_type'(int'(p.lcy) + ($urandom_range(0, 1) ? h : -h));
         end
      end else begin
         span  = (kind <= 5) ? 300 : 3000;
         p.lux = near_coord(span);  p.luy = near_coord(span);
         p.lvx = near_coord(span);  p.lvy = near_coord(span);
         p.rux = near_coord(span);  p.ruy = near_coord(span);
         p.rvx = near_coord(span);  p.rvy = near_coord(span);
         p.lcx = near_coord(20000);
         p.lcy = near_coord(20000);
         p.rcx = clip(int'(p.lcx) + near_value(3 * span));
         p.rcy = clip(int'(p.lcy) + near_value(3 * span));
      end
      return p;
   endfunction

   // Presents one request after the given number of idle cycles and returns
   // at the edge that takes it.
   task automatic send_pair(input box_pair_type p, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start              <= 1'b1;
      req_left_u_x       <= p.lux;
      req_left_u_y       <= p.luy;
      req_left_v_x       <= p.lvx;
      req_left_v_y       <= p.lvy;
      req_left_center_x  <= p.lcx;
      req_left_center_y  <= p.lcy;
      req_right_u_x      <= p.rux;
      req_right_u_y      <= p.ruy;
      req_right_v_x      <= p.rvx;
      req_right_v_y      <= p.rvy;
      req_right_center_x <= p.rcx;
      req_right_center_y <= p.rcy;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      bit burst;
      burst = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Degenerate boxes and the extremes of every field.
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_pair(make_pair(0, 0, 0, 0, -32768, -32768, 0, 0, 0, 0, 32767, 32767), 0);
      send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 32767, 32767), 1);
      send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768, -32768, -32768), 0);
      send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                          32767, 32767, 32767, 32767, 32767, 32767), 2);
      send_pair(make_pair(32767, -32768, -32768, 32767, 32767, -32768,
                          -32768, 32767, 32767, -32768, -32768, 32767), 0);
      send_pair(make_pair(-1, -1, -1, -1, 0, 0, -1, -1, -1, -1, 1, 1), 0);
      send_pair(make_pair(21845, -21846, -21846, 21845, 21845, -21846,
                          -21846, 21845, 21845, -21846, -21846, 21845), 3);
      // Unit squares touching along x, then one step apart, and the same along y.
      send_pair(make_pair(256, 0, 0, 256, 0, 0, 256, 0, 0, 256, 256, 0), 0);
      send_pair(make_pair(256, 0, 0, 256, 0, 0, 256, 0, 0, 256, 257, 0), 0);
      send_pair(make_pair(256, 0, 0, 256, 0, 0, 256, 0, 0, 256, 0, -256), 0);
      send_pair(make_pair(256, 0, 0, 256, 0, 0, 256, 0, 0, 256, 0, -257), 1);
      // A zero edge vector, and a box squeezed to a line.
      send_pair(make_pair(0, 0, 0, 256, 0, 0, 256, 0, 0, 256, 100, 0), 0);
      send_pair(make_pair(32767, 0, 0, 1, 0, 0, 256, 0, 0, 256, 0, 200), 0);
      // Rotated box near an axis-aligned one, overlapping and separated.
      send_pair(make_pair(181, 181, -181, 181, 0, 0, 256, 0, 0, 256, 300, 0), 0);
      send_pair(make_pair(181, 181, -181, 181, 0, 0, 256, 0, 0, 256, 600, 0), 0);

      drain_results();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 64 == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_REQUESTS / 2) begin
            drain_results();
         end
         send_pair(random_pair(), burst ? 0 : int'($urandom_range(0, 17)));
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
